### rtl/barometer_raw_compensation_defines.svh
// Assertion macros shared by the compensation block's modules.
`ifndef BAROMETER_RAW_COMPENSATION_DEFINES_SVH
`define BAROMETER_RAW_COMPENSATION_DEFINES_SVH

`ifndef SYNTHESIS
`define BPRC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define BPRC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BPRC_ASSERT_IMPL(lbl, ante, cons)
`define BPRC_ASSERT_NEVER(lbl, cond)
`endif

`endif

### rtl/bprc_pkg.sv
// Types and constants shared by the compensation block's modules.
package bprc_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int TD_N  = 27;  // quotient bits of the temperature division
  localparam int TD_DW = 20;  // divisor magnitude bits of the temperature division
  localparam int PD_N  = 32;  // quotient bits of the pressure division
  localparam int PD_DW = 17;  // divisor bits of the pressure division

  localparam logic [28:0] B6_OFFSET   = 29'd4000;
  localparam logic [11:0] P_SQ_COEF   = 12'd3038;
  localparam logic signed [14:0] P_LIN_COEF = -15'sd7357;
  localparam logic [47:0] P_OFFSET    = 48'd3791;
  localparam logic [31:0] B4_OFFSET   = 32'd32768;
  localparam logic [15:0] PRESS_SCALE = 16'd50000;
  localparam logic [17:0] PRESS_MAX   = 18'h3FFFF;

  typedef enum logic [1:0] {
    REG_TEMP_CAL     = 2'd0,
    REG_PRESS_LINEAR = 2'd1,
    REG_PRESS_SQUARE = 2'd2,
    REG_OVERSAMPLING = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] temp_cal_words;
    logic [63:0] press_cal_linear;
    logic [31:0] press_cal_square;
    logic [1:0]  oversampling;
  } cfg_t;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [23:0] raw_press;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temp_tenths;
    logic [17:0]        press_pascal;
    logic               div_error;
  } out_item_t;

  typedef struct packed {
    logic signed [18:0] x1;
    logic signed [19:0] den;
    logic [23:0]        up;
    logic               err;
  } q_entry_t;

endpackage

### rtl/barometer_raw_compensation.sv
// Top level of the barometric temperature and pressure compensation block.
//
// Usage: a transaction is offered by raising start with a raw temperature and
// raw pressure reading on item; it is taken at a rising edge where start is
// high and busy is low. Each transaction produces exactly one result on
// result, marked by done for a single cycle; the receiver cannot hold it off,
// so the result must be captured in that cycle.
// Calibration words and the oversampling setting are written through
// cfg_we, cfg_index and cfg_data, one register per cycle. The user must
// write them only while the block has no transaction in flight; the block
// itself does not enforce this.
// The result passes through the two one-bit-per-stage dividers (27 stages for
// the temperature quotient, 32 for the pressure quotient) plus the multiply
// stages around them. Throughput is one transaction per cycle: the pipeline
// never stalls and busy rises only if the four-entry queue between the front
// end and the compensation pipeline could overflow.
// A zero divisor in either division returns div_error with both values zero.
// Reset (rst, synchronous) clears all calibration registers to zero and
// drops every transaction in flight.
module barometer_raw_compensation import bprc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item,
  output logic        done,
  output out_item_t   result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t            cfg;
  logic            push;
  q_entry_t        push_data;
  logic            pop;
  q_entry_t        head;
  logic            empty;
  logic [Q_CW-1:0] q_count;

  // Configuration registers. Writes land in the cycle of the write enable and
  // take effect for the next transaction accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEMP_CAL:     cfg.temp_cal_words   <= cfg_data;
        REG_PRESS_LINEAR: cfg.press_cal_linear <= cfg_data;
        REG_PRESS_SQUARE: cfg.press_cal_square <= cfg_data[31:0];
        REG_OVERSAMPLING: cfg.oversampling     <= cfg_data[1:0];
        default:          cfg <= cfg;
      endcase
    end
  end

  // The front end forms the first temperature term and flags a zero
  // temperature divisor before the transaction is queued.
  bprc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .item      (item),
    .q_count   (q_count),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  bprc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .count     (q_count)
  );

  // The back end runs both divisions, the pressure polynomial and the final
  // saturation, producing one result per queued transaction.
  bprc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

### rtl/bprc_front.sv
// Front end: takes readings, forms the first temperature term and flags a zero divisor.
module bprc_front import bprc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            start,
  input  in_item_t        item,
  input  logic [Q_CW-1:0] q_count,
  output logic            busy,
  output logic            push,
  output q_entry_t        push_data
);

  logic                 accept;
  logic [Q_CW:0]        occupancy;
  logic [3:0]           shamt;
  logic signed [16:0]   diff;
  logic [23:0]          up_shift;
  logic                 f1_v;
  logic signed [16:0]   f1_diff;
  logic [23:0]          f1_up;
  logic                 f2_v;
  logic signed [33:0]   f2_prod;
  logic [23:0]          f2_up;
  logic signed [18:0]   x1;
  logic signed [19:0]   den;
  logic signed [15:0]   md;

  // Items in flight here still need a queue slot, so they count against it.
  always_comb begin
    occupancy = {1'b0, q_count} + {{Q_CW{1'b0}}, f1_v} + {{Q_CW{1'b0}}, f2_v};
    busy      = occupancy >= (Q_CW + 1)'(Q_DEPTH);
    accept    = start && !busy;
    shamt     = 4'd8 - {2'b00, cfg.oversampling};
    up_shift  = item.raw_press >> shamt;
    diff      = $signed({1'b0, item.raw_temp}) - $signed({1'b0, cfg.temp_cal_words[47:32]});
    md        = $signed(cfg.temp_cal_words[15:0]);
    x1        = f2_prod[33:15];
    den       = {x1[18], x1} + {{4{md[15]}}, md};
  end

  always_comb begin
    push          = f2_v;
    push_data.x1  = x1;
    push_data.den = den;
    push_data.up  = f2_up;
    push_data.err = (den == 20'sd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else begin
      f1_v <= accept;
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    f1_diff <= diff;
    f1_up   <= up_shift;
    f2_prod <= f1_diff * $signed({1'b0, cfg.temp_cal_words[63:48]});
    f2_up   <= f1_up;
  end

endmodule

### rtl/bprc_queue.sv
// Short queue between the front end and the compensation pipeline.
module bprc_queue import bprc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  q_entry_t        push_data,
  input  logic            pop,
  output q_entry_t        head,
  output logic            empty,
  output logic [Q_CW-1:0] count
);

  q_entry_t        entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic            full;

  always_comb begin
    empty = (count == '0);
    full  = (count == Q_CW'(Q_DEPTH));
    head  = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + Q_CW'(push) - Q_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `include "barometer_raw_compensation_defines.svh"

  `BPRC_ASSERT_NEVER(a_no_overflow, push && full && !pop)
  `BPRC_ASSERT_NEVER(a_no_underflow, pop && empty)
  `BPRC_ASSERT_IMPL(a_count_bound, 1'b1, count <= Q_CW'(Q_DEPTH))

endmodule

### rtl/bprc_back.sv
// Compensation pipeline: both divisions, the pressure polynomial and saturation.
module bprc_back import bprc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  q_entry_t  head,
  input  logic      empty,
  output logic      pop,
  output logic      done,
  output out_item_t result
);

  localparam int BACK_LAT = TD_N + PD_N + 10;

  typedef struct packed {
    logic [TD_DW-1:0]   rem;
    logic [TD_N-1:0]    qd;
    logic [TD_DW-1:0]   dv;
    logic               neg;
    logic signed [18:0] x1;
    logic [23:0]        up;
    logic               err;
  } td_stage_t;

  typedef struct packed {
    logic [PD_DW-1:0]   rem;
    logic [PD_N-1:0]    qd;
    logic [PD_DW-1:0]   dv;
    logic               dbl;
    logic signed [15:0] temp;
    logic               err;
  } pd_stage_t;

  logic signed [15:0] ac1, ac2, ac3, mc, b1, b2;
  logic [15:0]        ac4, scale;

  logic signed [26:0] num;
  logic [TD_N-1:0]    num_mag;
  logic [TD_DW-1:0]   den_mag;

  td_stage_t td   [TD_N+1];
  logic      td_v [TD_N+1];
  pd_stage_t pd   [PD_N+1];
  logic      pd_v [PD_N+1];

  // Stage signals after the temperature division.
  logic signed [27:0] x2;
  logic signed [28:0] b5, tsum, b6;
  logic signed [24:0] t25;
  logic signed [15:0] tsat;
  logic               s1_v, s1_err;
  logic [23:0]        s1_up;
  logic signed [15:0] s1_temp;
  logic signed [28:0] s1_b6;

  logic               s2_v, s2_err;
  logic [23:0]        s2_up;
  logic signed [15:0] s2_temp;
  logic signed [57:0] s2_sqf;
  logic signed [44:0] s2_mac2, s2_mac3;

  logic               s3_v, s3_err;
  logic [23:0]        s3_up;
  logic signed [15:0] s3_temp;
  logic signed [62:0] s3_pb2, s3_pb1;
  logic [33:0]        s3_x2a;
  logic [31:0]        s3_x1b;

  logic               s4_v, s4_err;
  logic [23:0]        s4_up;
  logic signed [15:0] s4_temp;
  logic [33:0]        s4_x3a, s4_s34;

  logic [33:0]        lin_sum, lin_shift, b3_num;
  logic               s5_v, s5_err;
  logic signed [15:0] s5_temp;
  logic [31:0]        s5_d, s5_b4arg;

  logic [47:0]        b7_full, b4_full;
  logic               s6_v, s6_err;
  logic signed [15:0] s6_temp;
  logic [31:0]        s6_b7;
  logic [PD_DW-1:0]   s6_b4;

  // Stage signals after the pressure division.
  logic [32:0]        q33;
  logic               s8_v, s8_err;
  logic signed [15:0] s8_temp;
  logic [32:0]        s8_q;
  logic [49:0]        s8_sqp;
  logic signed [47:0] s8_mlin;

  logic [61:0]        sq_coef;
  logic               s9_v, s9_err;
  logic signed [15:0] s9_temp;
  logic [32:0]        s9_q;
  logic [45:0]        s9_x1;
  logic signed [31:0] s9_x2;

  logic signed [47:0] tot;
  logic signed [44:0] pf;
  logic [17:0]        psat;

  always_comb begin
    ac1   = $signed(cfg.press_cal_linear[63:48]);
    ac2   = $signed(cfg.press_cal_linear[47:32]);
    ac3   = $signed(cfg.press_cal_linear[31:16]);
    ac4   = cfg.press_cal_linear[15:0];
    mc    = $signed(cfg.temp_cal_words[31:16]);
    b1    = $signed(cfg.press_cal_square[31:16]);
    b2    = $signed(cfg.press_cal_square[15:0]);
    scale = PRESS_SCALE >> cfg.oversampling;
  end

  // The pipeline never stalls, so any queued entry is taken at once.
  always_comb begin
    pop     = !empty;
    num     = $signed({mc, 11'b0});
    num_mag = num[26] ? TD_N'(-num) : TD_N'(num);
    den_mag = head.den[19] ? TD_DW'(-head.den) : TD_DW'(head.den);
  end

  always_ff @(posedge clk) begin
    td[0].rem <= '0;
    td[0].qd  <= num_mag;
    td[0].dv  <= den_mag;
    td[0].neg <= num[26] ^ head.den[19];
    td[0].x1  <= head.x1;
    td[0].up  <= head.up;
    td[0].err <= head.err;
  end

  // Signed quotient with truncation toward zero, one bit per stage.
  for (genvar k = 0; k < TD_N; k++) begin : g_tdiv
    logic [TD_DW:0] rs;
    logic           ge;
    td_stage_t      nxt;
    always_comb begin
      rs      = {td[k].rem, td[k].qd[TD_N-1]};
      ge      = rs >= {1'b0, td[k].dv};
      nxt     = td[k];
      nxt.qd  = {td[k].qd[TD_N-2:0], ge};
      nxt.rem = ge ? TD_DW'(rs - {1'b0, td[k].dv}) : rs[TD_DW-1:0];
    end
    always_ff @(posedge clk) begin
      td[k+1] <= nxt;
    end
  end

  always_comb begin
    x2   = td[TD_N].neg ? -$signed({1'b0, td[TD_N].qd}) : $signed({1'b0, td[TD_N].qd});
    b5   = 29'(td[TD_N].x1) + 29'(x2);
    tsum = b5 + 29'sd8;
    t25  = tsum[28:4];
    if (t25 > 25'sd32767) begin
      tsat = 16'sd32767;
    end else if (t25 < -25'sd32768) begin
      tsat = -16'sd32768;
    end else begin
      tsat = t25[15:0];
    end
    b6   = b5 - $signed(B6_OFFSET);
  end

  always_comb begin
    lin_sum   = {{16{ac1[15]}}, ac1, 2'b00} + s4_x3a;
    lin_shift = lin_sum << cfg.oversampling;
    b3_num    = lin_shift + 34'd2;
    b7_full   = s5_d * scale;
    b4_full   = ac4 * s5_b4arg;
  end

  always_ff @(posedge clk) begin
    s1_up   <= td[TD_N].up;
    s1_err  <= td[TD_N].err;
    s1_temp <= tsat;
    s1_b6   <= b6;

    s2_up   <= s1_up;
    s2_err  <= s1_err;
    s2_temp <= s1_temp;
    s2_sqf  <= s1_b6 * s1_b6;
    s2_mac2 <= ac2 * s1_b6;
    s2_mac3 <= ac3 * s1_b6;

    s3_up   <= s2_up;
    s3_err  <= s2_err;
    s3_temp <= s2_temp;
    s3_pb2  <= b2 * $signed({1'b0, s2_sqf[57:12]});
    s3_pb1  <= b1 * $signed({1'b0, s2_sqf[57:12]});
    s3_x2a  <= s2_mac2[44:11];
    s3_x1b  <= s2_mac3[44:13];

    // Only the low 34 bits matter downstream: B3 and B4 wrap to 32 bits.
    s4_up   <= s3_up;
    s4_err  <= s3_err;
    s4_temp <= s3_temp;
    s4_x3a  <= s3_pb2[44:11] + s3_x2a;
    s4_s34  <= s3_pb1[49:16] + {{2{s3_x1b[31]}}, s3_x1b} + 34'd2;

    s5_err   <= s4_err;
    s5_temp  <= s4_temp;
    s5_d     <= {8'b0, s4_up} - b3_num[33:2];
    s5_b4arg <= s4_s34[33:2] + B4_OFFSET;

    s6_err  <= s5_err;
    s6_temp <= s5_temp;
    s6_b7   <= b7_full[31:0];
    s6_b4   <= b4_full[31:15];
  end

  always_ff @(posedge clk) begin
    pd[0].rem  <= '0;
    pd[0].qd   <= s6_b7[31] ? s6_b7 : {s6_b7[30:0], 1'b0};
    pd[0].dv   <= s6_b4;
    pd[0].dbl  <= s6_b7[31];
    pd[0].temp <= s6_temp;
    pd[0].err  <= s6_err || (s6_b4 == '0);
  end

  for (genvar k = 0; k < PD_N; k++) begin : g_pdiv
    logic [PD_DW:0] rs;
    logic           ge;
    pd_stage_t      nxt;
    always_comb begin
      rs      = {pd[k].rem, pd[k].qd[PD_N-1]};
      ge      = rs >= {1'b0, pd[k].dv};
      nxt     = pd[k];
      nxt.qd  = {pd[k].qd[PD_N-2:0], ge};
      nxt.rem = ge ? PD_DW'(rs - {1'b0, pd[k].dv}) : rs[PD_DW-1:0];
    end
    always_ff @(posedge clk) begin
      pd[k+1] <= nxt;
    end
  end

  always_comb begin
    q33     = pd[PD_N].dbl ? {pd[PD_N].qd, 1'b0} : {1'b0, pd[PD_N].qd};
    sq_coef = s8_sqp * P_SQ_COEF;
    tot     = $signed({2'b00, s9_x1}) + 48'(s9_x2) + $signed(P_OFFSET);
    // The correction term is usually negative, so it is sign-extended.
    pf      = $signed({12'b0, s9_q}) + 45'($signed(tot[47:4]));
    if (pf < 45'sd0) begin
      psat = '0;
    end else if (pf > $signed({27'b0, PRESS_MAX})) begin
      psat = PRESS_MAX;
    end else begin
      psat = pf[17:0];
    end
  end

  always_ff @(posedge clk) begin
    s8_err  <= pd[PD_N].err;
    s8_temp <= pd[PD_N].temp;
    s8_q    <= q33;
    s8_sqp  <= q33[32:8] * q33[32:8];
    s8_mlin <= P_LIN_COEF * $signed({1'b0, q33});

    s9_err  <= s8_err;
    s9_temp <= s8_temp;
    s9_q    <= s8_q;
    s9_x1   <= sq_coef[61:16];
    s9_x2   <= s8_mlin[47:16];

    result.div_error    <= s9_err;
    result.temp_tenths  <= s9_err ? 16'sd0 : s9_temp;
    result.press_pascal <= s9_err ? 18'd0 : psat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      td_v[0] <= 1'b0;
      pd_v[0] <= 1'b0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_v    <= 1'b0;
      s4_v    <= 1'b0;
      s5_v    <= 1'b0;
      s6_v    <= 1'b0;
      s8_v    <= 1'b0;
      s9_v    <= 1'b0;
      done    <= 1'b0;
    end else begin
      td_v[0] <= pop;
      s1_v    <= td_v[TD_N];
      s2_v    <= s1_v;
      s3_v    <= s2_v;
      s4_v    <= s3_v;
      s5_v    <= s4_v;
      s6_v    <= s5_v;
      pd_v[0] <= s6_v;
      s8_v    <= pd_v[PD_N];
      s9_v    <= s8_v;
      done    <= s9_v;
    end
  end

  for (genvar k = 0; k < TD_N; k++) begin : g_tdiv_v
    always_ff @(posedge clk) begin
      if (rst) begin
        td_v[k+1] <= 1'b0;
      end else begin
        td_v[k+1] <= td_v[k];
      end
    end
  end

  for (genvar k = 0; k < PD_N; k++) begin : g_pdiv_v
    always_ff @(posedge clk) begin
      if (rst) begin
        pd_v[k+1] <= 1'b0;
      end else begin
        pd_v[k+1] <= pd_v[k];
      end
    end
  end

  `include "barometer_raw_compensation_defines.svh"

  `BPRC_ASSERT_IMPL(a_err_zeroes, done && result.div_error, result.temp_tenths == 16'sd0 && result.press_pascal == 18'd0)
  `BPRC_ASSERT_IMPL(a_fixed_latency, done, $past(td_v[0], BACK_LAT))

endmodule
